/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define ASSERT_OFF to drop
// every assertion from a build.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: label");

// Expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: label");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* src/wbps_pkg.sv */
// ---------------------------------------------------------------------------
// wbps_pkg
// Shared widths, reset values, codes and types of the wildcard byte pattern
// search.
// ---------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	// Parameter defaults
	localparam int PATTERN_MAX_DEF   = 64;
	localparam int POSITION_BITS_DEF = 20;

	// Fixed field widths
	localparam int BYTE_W     = 8;
	localparam int BASE_W     = 20;
	localparam int LEN_W      = 7;
	localparam int POS_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Register reset values
	localparam logic [BASE_W-1:0] BASE_RESET = '0;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd1;
	localparam logic [BYTE_W-1:0] WILD_RESET = 8'd244;

	// Item modes
	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_SCAN = 1'b1
	} mode_t;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_BASE    = 2'd0,
		REG_PATTERN_LENGTH = 2'd1,
		REG_WILD_BYTE      = 2'd2
	} reg_idx_t;

	// One accepted word as seen by the match core
	typedef struct packed {
		logic              load;
		logic              scan;
		logic              last;
		logic [BYTE_W-1:0] data;
	} step_t;

endpackage

`default_nettype wire

/* src/wbps_if.sv */
// ---------------------------------------------------------------------------
// wbps_if
// Valid/ready channels of the pattern search: input words and results.
// ---------------------------------------------------------------------------
`default_nettype none

interface wbps_item_if import wbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [BYTE_W-1:0] data_byte;
	logic              last;

	modport source (output valid, output mode, output data_byte, output last, input ready);
	modport sink   (input valid, input mode, input data_byte, input last, output ready);
endinterface

interface wbps_result_if import wbps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] match_position;

	modport source (output valid, output found, output match_position, input ready);
	modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

/* src/wildcard_byte_pattern_search_top.sv */
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_search_top
// Streams pattern and window bytes, reports the earliest wildcard match of
// each window as an absolute position.
// ---------------------------------------------------------------------------
//
//   channel  dir  payload                        word moved when
//   item     in   mode, data_byte, last          item.valid && item.ready
//   result   out  found, match_position          result.valid && result.ready
//   cfg      in   cfg_idx, cfg_wdata             cfg_we
//
// One word is taken each cycle while the skid register is empty. All compare
// work for a word runs in the cycle it is accepted: a log shifter lines the
// history up with the pattern and all PATTERN_MAX lanes compare at once. The
// result of a window's last byte is registered in the result register; a second
// result waits in a skid register, so input stalls only when both are full.
// Reset clears all control state at once; there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wildcard_byte_pattern_search_top import wbps_pkg::*; #(
	parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	wbps_item_if.sink                  item,
	wbps_result_if.source              result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [BASE_W-1:0]        base_q;
	logic [LEN_W-1:0]         len_q;
	logic [BYTE_W-1:0]        wild_q;
	logic                     accept;
	step_t                    step;
	logic                     hit_found;
	logic [POSITION_BITS-1:0] hit_offset;
	logic [POSITION_BITS-1:0] pos_sum;
	logic                     new_res;
	logic                     new_found;
	logic [POS_W-1:0]         new_pos;
	logic                     pop;
	logic                     out_valid_q, skid_valid_q;
	logic                     out_found_q, skid_found_q;
	logic [POS_W-1:0]         out_pos_q, skid_pos_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			len_q  <= LEN_RESET;
			wild_q <= WILD_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_WINDOW_BASE:    base_q <= cfg_wdata[BASE_W-1:0];
				REG_PATTERN_LENGTH: len_q  <= cfg_wdata[LEN_W-1:0];
				REG_WILD_BYTE:      wild_q <= cfg_wdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode the accepted word
	assign item.ready = !skid_valid_q;
	assign accept     = item.valid && item.ready;

	always_comb begin
		step.load = accept && (item.mode == MODE_LOAD);
		step.scan = accept && (item.mode == MODE_SCAN);
		step.last = item.last;
		step.data = item.data_byte;
	end

	wbps_match #(
		.PATTERN_MAX   (PATTERN_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.pat_len    (len_q),
		.wild       (wild_q),
		.hit_found  (hit_found),
		.hit_offset (hit_offset)
	);

	// Absolute position, wrapping within the position width
	always_comb begin
		pos_sum   = POSITION_BITS'(POSITION_BITS'(base_q) + hit_offset);
		new_res   = step.scan && step.last;
		new_found = hit_found;
		new_pos   = hit_found ? POS_W'(pos_sum) : '0;
	end

	// Result register with one skid entry behind it
	assign pop = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= new_res;
			end else begin
				out_valid_q  <= new_res;
			end
		end else if (new_res) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_found_q  <= skid_found_q;
				out_pos_q    <= skid_pos_q;
				skid_found_q <= new_found;
				skid_pos_q   <= new_pos;
			end else begin
				out_found_q  <= new_found;
				out_pos_q    <= new_pos;
			end
		end else if (new_res) begin
			skid_found_q <= new_found;
			skid_pos_q   <= new_pos;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.found          = out_found_q;
	assign result.match_position = out_pos_q;

	// Checks
	`ASSERT_CLK(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`ASSERT_CLK(a_result_from_last, clk, arst_n, $rose(out_valid_q) |-> $past(accept && item.mode == MODE_SCAN && item.last))
	`ASSERT_NEVER(a_miss_has_no_pos, clk, arst_n, out_valid_q && !out_found_q && out_pos_q != '0)

endmodule

`default_nettype wire

/* src/wbps_match.sv */
// ---------------------------------------------------------------------------
// wbps_match
// Pattern store, byte history and parallel wildcard compare. Gives the
// window's match state as it stands after the current word.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_match import wbps_pkg::*; #(
	parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire step_t                    step,
	input  wire logic [LEN_W-1:0]         pat_len,
	input  wire logic [BYTE_W-1:0]        wild,
	output logic                          hit_found,
	output logic [POSITION_BITS-1:0]      hit_offset
);

	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam logic [POSITION_BITS-1:0] CNT_MAX = {POSITION_BITS{1'b1}};
	localparam logic [AW-1:0] PTR_LAST = AW'(PATTERN_MAX - 1);

	logic [BYTE_W-1:0]        pat_q   [PATTERN_MAX];
	logic [BYTE_W-1:0]        hist_q  [PATTERN_MAX];
	logic [BYTE_W-1:0]        hist_n  [PATTERN_MAX];
	logic [BYTE_W-1:0]        aligned [PATTERN_MAX];
	logic [AW-1:0]            load_ptr_q;
	logic [POSITION_BITS-1:0] cnt_q, cnt_n;
	logic                     seen_q;
	logic [POSITION_BITS-1:0] off_q, off_n;
	logic [LW-1:0]            len_u;
	logic [AW-1:0]            shift_amt;
	logic [PATTERN_MAX-1:0]   lane_ok;
	logic                     tail_hit;
	logic                     new_hit;

	// Clamp the length into 1..PATTERN_MAX
	always_comb begin
		if (pat_len == '0) begin
			len_u = LW'(1);
		end else if (int'(pat_len) > PATTERN_MAX) begin
			len_u = LW'(PATTERN_MAX);
		end else begin
			len_u = LW'(pat_len);
		end
		shift_amt = AW'(PATTERN_MAX - int'(len_u));
	end

	// History after the new byte: newest at entry zero
	always_comb begin
		hist_n[0] = step.data;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			hist_n[i] = hist_q[i-1];
		end
	end

	// Line up the newest len_u bytes with the pattern: a log shifter over
	// the reversed history, so that aligned[j] is the byte under pattern j
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			aligned[i] = hist_n[PATTERN_MAX-1-i];
		end
		for (int b = 0; b < AW; b++) begin
			if (shift_amt[b]) begin
				for (int j = 0; j < PATTERN_MAX; j++) begin
					aligned[j] = (j + (1 << b) < PATTERN_MAX) ? aligned[j + (1 << b)] : '0;
				end
			end
		end
	end

	// Compare every lane; lanes past the length always pass
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			lane_ok[j] = (j >= int'(len_u)) || (pat_q[j] == wild) || (pat_q[j] == aligned[j]);
		end
		tail_hit = &lane_ok;
	end

	// Saturating byte count and first-match capture
	always_comb begin
		cnt_n   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
		new_hit = !seen_q && (32'(cnt_n) >= 32'(len_u)) && tail_hit;
		off_n   = new_hit ? POSITION_BITS'(cnt_n - POSITION_BITS'(len_u)) : off_q;
	end

	assign hit_found  = seen_q || new_hit;
	assign hit_offset = off_n;

	// Pattern store: written in load order, no reset
	always_ff @(posedge clk) begin
		if (step.load) begin
			pat_q[load_ptr_q] <= step.data;
		end
	end

	// Load pointer: advance and wrap, rewind on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
		end else if (step.load) begin
			if (step.last || load_ptr_q == PTR_LAST) begin
				load_ptr_q <= '0;
			end else begin
				load_ptr_q <= load_ptr_q + 1'b1;
			end
		end
	end

	// Window state: shift on each source byte, drop all at the window's end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				hist_q[i] <= '0;
			end
			cnt_q  <= '0;
			seen_q <= 1'b0;
			off_q  <= '0;
		end else if (step.scan) begin
			if (step.last) begin
				for (int i = 0; i < PATTERN_MAX; i++) begin
					hist_q[i] <= '0;
				end
				cnt_q  <= '0;
				seen_q <= 1'b0;
				off_q  <= '0;
			end else begin
				hist_q <= hist_n;
				cnt_q  <= cnt_n;
				seen_q <= seen_q || new_hit;
				off_q  <= off_n;
			end
		end
	end

endmodule

`default_nettype wire

/* dv/wildcard_byte_pattern_search_top_tb.sv */
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_search_top_tb
// Self-checking bench for the wildcard byte pattern search. Pattern and window
// words are queued by a stimulus process and driven over the item channel.
// A behavioural image of the search core predicts one match report per
// window, and the result channel is compared field by field against it.
// Runs a directed opener and randomised phases with sender and receiver gaps.
// ---------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_search_top_tb;
	import wbps_pkg::*;

	localparam int HIST_W      = PATTERN_MAX_DEF * BYTE_W;
	localparam int CYCLE_LIMIT = 100_000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 222;

	// Index past the three registers; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		mode_t             mode;
		logic [BYTE_W-1:0] data;
		logic              last;
	} search_word_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} match_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wbps_item_if   item_ch();
	wbps_result_if result_ch();

	wildcard_byte_pattern_search_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Words waiting to go out, and reports owed by the block
	search_word_t  words_to_send [$];
	match_report_t reports_due [$];

	int idle_pct;
	int stall_pct;
	int fail_count;
	int words_accepted;
	int words_pushed;
	int reports_checked;
	int reports_found;
	int cycle_count;

	// Image of the block: registers, pattern store and window state
	logic [BASE_W-1:0] base_reg;
	logic [LEN_W-1:0]  len_reg;
	logic [BYTE_W-1:0] wild_reg;
	logic [BYTE_W-1:0] pat_mem [PATTERN_MAX_DEF];
	logic [5:0]        pat_ptr;
	logic [HIST_W-1:0] history;
	logic [POS_W-1:0]  scan_count;
	logic              hit_seen;
	logic [POS_W-1:0]  hit_offset;

	// Pattern as the stimulus side will have loaded it once the queue drains
	logic [BYTE_W-1:0] staged_pat [PATTERN_MAX_DEF];
	logic [5:0]        staged_ptr;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Clamp the length register to the range the core uses
	function automatic int unsigned eff_len();
		if (len_reg == '0)
			return 1;
		if (len_reg > PATTERN_MAX_DEF)
			return PATTERN_MAX_DEF;
		return len_reg;
	endfunction

	// Advance the image by one accepted word; queue a report on a window's last byte
	function automatic void scan_predict(input mode_t mode, input logic [BYTE_W-1:0] b,
			input logic last);
		int unsigned   n;
		bit            ok;
		match_report_t rep;
		if (mode == MODE_LOAD) begin
			pat_mem[pat_ptr] = b;
			pat_ptr = last ? 6'd0 : pat_ptr + 6'd1;
		end else begin
			history = {history[HIST_W-BYTE_W-1:0], b};
			if (scan_count != '1)
				scan_count = scan_count + 1'b1;
			n = eff_len();
			if (!hit_seen && scan_count >= n) begin
				ok = 1'b1;
				for (int j = 0; j < n; j++) begin
					if (pat_mem[j] != history[(n-1-j)*BYTE_W +: BYTE_W] &&
							pat_mem[j] != wild_reg)
						ok = 1'b0;
				end
				if (ok) begin
					hit_seen = 1'b1;
					hit_offset = scan_count - n[POS_W-1:0];
				end
			end
			if (last) begin
				rep.found = hit_seen;
				rep.position = hit_seen ? base_reg + hit_offset : '0;
				reports_due.push_back(rep);
				history = '0;
				scan_count = '0;
				hit_seen = 1'b0;
				hit_offset = '0;
			end
		end
	endfunction

	// Drive words; predict on every accepted one
	always @(posedge clk or negedge arst_n) begin : drive_words
		search_word_t w;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.mode <= MODE_LOAD;
			item_ch.data_byte <= '0;
			item_ch.last <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				scan_predict(mode_t'(item_ch.mode), item_ch.data_byte, item_ch.last);
				words_accepted++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
					w = words_to_send.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.mode <= w.mode;
					item_ch.data_byte <= w.data;
					item_ch.last <= w.last;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Take reports and compare them with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_reports
		match_report_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (reports_due.size() == 0) begin
					$error("report with none expected: found=%0b match_position=%0h",
						result_ch.found, result_ch.match_position);
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					reports_checked++;
					if (want.found)
						reports_found++;
					if (result_ch.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, result_ch.found);
						fail_count++;
					end
					if (result_ch.match_position !== want.position) begin
						$error("match_position: expected %0h, got %0h",
							want.position, result_ch.match_position);
						fail_count++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void push_word(input mode_t mode, input logic [BYTE_W-1:0] b,
			input logic last);
		search_word_t w;
		w.mode = mode;
		w.data = b;
		w.last = last;
		words_to_send.push_back(w);
		words_pushed++;
		if (mode == MODE_LOAD) begin
			staged_pat[staged_ptr] = b;
			staged_ptr = last ? 6'd0 : staged_ptr + 6'd1;
		end
	endfunction

	// Either a byte from the pattern or a rail value, or anything at all
	function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow);
		if (!narrow)
			return BYTE_W'($urandom_range(255));
		if ($urandom_range(1))
			return staged_pat[$urandom_range(eff_len() - 1)];
		return $urandom_range(1) ? 8'hFF : 8'h00;
	endfunction

	// Reload the pattern in full, some bytes set to the wildcard
	function automatic void push_reload(input bit narrow);
		int unsigned n;
		logic [BYTE_W-1:0] b;
		n = eff_len();
		for (int j = 0; j < n; j++) begin
			b = ($urandom_range(3) == 0) ? wild_reg : pick_byte(narrow);
			push_word(MODE_LOAD, b, j == n - 1);
		end
	endfunction

	// One window of n bytes, optionally with the pattern planted at a random offset
	function automatic void push_window(input int n, input bit plant, input bit narrow);
		logic [BYTE_W-1:0] win [256];
		int unsigned       len;
		int                off;
		len = eff_len();
		for (int i = 0; i < n; i++)
			win[i] = pick_byte(narrow);
		if (plant && n >= len) begin
			off = $urandom_range(n - len);
			for (int j = 0; j < len; j++) begin
				if (staged_pat[j] != wild_reg)
					win[off+j] = staged_pat[j];
			end
		end
		for (int i = 0; i < n; i++)
			push_word(MODE_SCAN, win[i], i == n - 1);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW_BASE:    base_reg = data[BASE_W-1:0];
			REG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
			REG_WILD_BYTE:      wild_reg = data[BYTE_W-1:0];
			default: ;
		endcase
	endtask

	// Hold until everything sent has been taken and every report has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (words_to_send.size() != 0 || item_ch.valid || reports_due.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// Random phase: new settings, gap profile, then mostly well-formed traffic
	task automatic run_phase(input int k);
		logic [CFG_DATA_W-1:0] data;
		logic [LEN_W-1:0]      len;
		int                    start;
		int                    r;
		int                    n;
		wait_idle();
		data = (k == 0) ? '0 : (k == 1) ? '1 : CFG_DATA_W'($urandom);
		write_reg(REG_WINDOW_BASE, data);
		case (k)
			0: len = 7'd1;
			1: len = 7'd8;
			2: len = 7'd0;
			3: len = 7'd64;
			4: len = 7'd3;
			5: len = 7'd127;
			6: len = 7'd12;
			default: len = LEN_W'($urandom_range(2, 6));
		endcase
		data = CFG_DATA_W'($urandom);
		data[LEN_W-1:0] = len;
		write_reg(REG_PATTERN_LENGTH, data);
		data = CFG_DATA_W'($urandom);
		data[BYTE_W-1:0] = (k == 0) ? 8'h00 : (k == 3) ? 8'hFF :
			BYTE_W'($urandom_range(255));
		write_reg(REG_WILD_BYTE, data);
		case (k % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 71; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 71; end
			default: begin idle_pct = 11; stall_pct = 11; end
		endcase
		start = words_pushed;
		push_reload(1'($urandom_range(1)));
		while (words_pushed - start < PHASE_WORDS) begin
			r = $urandom_range(99);
			if (r < 10) begin
				push_reload(1'($urandom_range(1)));
			end else if (r < 15) begin
				// stray loads that may leave the pointer part way
				n = $urandom_range(1, 80);
				for (int i = 0; i < n; i++)
					push_word(MODE_LOAD, BYTE_W'($urandom_range(255)),
						(i == n - 1) && $urandom_range(1));
			end else begin
				r = $urandom_range(99);
				if (r < 60)
					n = $urandom_range(1, eff_len() + 6);
				else if (r < 90)
					n = $urandom_range(1, 24);
				else
					n = $urandom_range(1, 150);
				push_window(n, $urandom_range(99) < 55, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_WINDOW_BASE;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_LOAD;
		item_ch.data_byte = '0;
		item_ch.last = 1'b0;
		result_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		fail_count = 0;
		words_accepted = 0;
		words_pushed = 0;
		reports_checked = 0;
		reports_found = 0;
		cycle_count = 0;
		base_reg = BASE_RESET;
		len_reg = LEN_RESET;
		wild_reg = WILD_RESET;
		for (int i = 0; i < PATTERN_MAX_DEF; i++) begin
			pat_mem[i] = '0;
			staged_pat[i] = '0;
		end
		pat_ptr = '0;
		staged_ptr = '0;
		history = '0;
		scan_count = '0;
		hit_seen = 1'b0;
		hit_offset = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opener: four-byte pattern with one wildcard, upper data bits set
		write_reg(REG_WINDOW_BASE, 20'h12345);
		write_reg(REG_PATTERN_LENGTH, 20'hABC84);
		write_reg(REG_WILD_BYTE, 20'h7F0C3);
		write_reg(REG_SPARE, '1);

		// fill every entry, wrap the pointer, then rewind it with last
		for (int i = 0; i < PATTERN_MAX_DEF; i++)
			push_word(MODE_LOAD, BYTE_W'($urandom_range(255)), 1'b0);
		push_word(MODE_LOAD, 8'h00, 1'b1);

		push_word(MODE_LOAD, 8'h00, 1'b0);
		push_word(MODE_LOAD, 8'hC3, 1'b0);
		push_word(MODE_LOAD, 8'hFF, 1'b0);
		push_word(MODE_LOAD, 8'h5A, 1'b1);
		// match right at the start of the window
		push_word(MODE_SCAN, 8'h00, 1'b0);
		push_word(MODE_SCAN, 8'h77, 1'b0);
		push_word(MODE_SCAN, 8'hFF, 1'b0);
		push_word(MODE_SCAN, 8'h5A, 1'b1);
		// window shorter than the pattern
		push_word(MODE_SCAN, 8'h00, 1'b0);
		push_word(MODE_SCAN, 8'h11, 1'b0);
		push_word(MODE_SCAN, 8'hFF, 1'b1);
		// two matches; the earlier one must be reported
		push_word(MODE_SCAN, 8'h5A, 1'b0);
		push_word(MODE_SCAN, 8'h00, 1'b0);
		push_word(MODE_SCAN, 8'hFF, 1'b0);
		push_word(MODE_SCAN, 8'hFF, 1'b0);
		push_word(MODE_SCAN, 8'h5A, 1'b0);
		push_word(MODE_SCAN, 8'h00, 1'b0);
		push_word(MODE_SCAN, 8'h01, 1'b0);
		push_word(MODE_SCAN, 8'hFF, 1'b0);
		push_word(MODE_SCAN, 8'h5A, 1'b1);
		// single-byte window
		push_word(MODE_SCAN, 8'hFF, 1'b1);

		for (int k = 0; k < PHASES; k++)
			run_phase(k);

		wait_idle();
		$display("Sent %0d words over %0d setting phases with sender and receiver gaps;",
			words_accepted, PHASES + 1);
		$display("checked %0d window reports (%0d matches).",
			reports_checked, reports_found);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
